[sv/ialu_pkg.sv]
// ----------------------------------------------------------------------------
// ialu_pkg
// Shared types and codes for the integer alu with condition flags.
// ----------------------------------------------------------------------------
package ialu_pkg;

    typedef enum logic [3:0] {
        FUNC_ADD  = 4'd0,
        FUNC_SUB  = 4'd1,
        FUNC_MUL  = 4'd2,
        FUNC_DIV  = 4'd3,
        FUNC_BIS  = 4'd4,
        FUNC_BIC  = 4'd5,
        FUNC_XOR  = 4'd6,
        FUNC_ADWC = 4'd7,
        FUNC_SBWC = 4'd8
    } func_t;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;
    localparam logic [1:0] SIZE_LONG = 2'd2;
    localparam logic [1:0] SIZE_BAD  = 2'd3;

    typedef struct packed {
        logic [3:0]  func;
        logic [1:0]  size;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
    } ialu_in_t;

    typedef struct packed {
        logic [31:0] result;
        logic        flag_n;
        logic        flag_z;
        logic        flag_v;
        logic        flag_c;
        logic        fault;
    } ialu_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIX,
        ST_DONE
    } state_t;

    // request from sequencer to the shared iterative unit
    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [31:0] mag_a;
        logic [31:0] mag_b;
    } iter_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] prod;
        logic [31:0] quot;
    } iter_rsp_t;

endpackage

[sv/ialu_iter.sv]
// ----------------------------------------------------------------------------
// ialu_iter
// Shared shift-add multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module ialu_iter
    import ialu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  iter_req_t req,
    output iter_rsp_t rsp
);

    logic [63:0] acc_reg, acc_next;
    logic [31:0] opr_reg, opr_next;
    logic [31:0] q_reg, q_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        div_reg, div_next;
    logic [32:0] trial;
    logic [31:0] sh;

    // one multiply or divide step per cycle, a trial subtract for divide and an add for multiply
    always_comb
    begin
        acc_next  = acc_reg;
        opr_next  = opr_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        div_next  = div_reg;
        sh        = {acc_reg[30:0], q_reg[31]};
        trial     = {1'b0, sh} - {1'b0, opr_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            div_next  = req.is_div;
            cnt_next  = 6'd0;
            opr_next  = req.mag_a;
            acc_next  = 64'd0;
            q_next    = req.mag_b;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                // restoring step: remainder in acc low half, dividend bits from q msb
                if (!trial[32])
                    acc_next = {32'd0, trial[31:0]};
                else
                    acc_next = {32'd0, sh};
                q_next = {q_reg[30:0], ~trial[32]};
            end
            else
            begin
                // multiplier bits taken from q lsb first
                acc_next = {1'b0, acc_reg[63:1]};
                if (q_reg[0])
                    acc_next[63:31] = {1'b0, acc_reg[63:32]} + {1'b0, opr_reg};
                q_next = {1'b0, q_reg[31:1]};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
            div_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            div_reg  <= div_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        opr_reg <= opr_next;
        q_reg   <= q_next;
    end

    assign rsp.done = busy_reg && (cnt_reg == 6'd31);
    assign rsp.prod = acc_next;
    assign rsp.quot = q_next;

endmodule

[sv/integer_alu_with_flags_unit.sv]
// ----------------------------------------------------------------------------
// integer_alu_with_flags_unit
// Integer alu on byte, word and longword with N Z V C condition flags.
// ----------------------------------------------------------------------------
// sequence: idle takes the word, fix works it; add, sub, logic and divide by zero
// go on to done, mul and div first run 32 steps of the shared shift-add / restoring
// unit, one bit per cycle; in_ready is low while a word is at work, and the result
// register lets the next word in while the result waits
// reset: flags cleared, sequencer idle, no result pending
module integer_alu_with_flags_unit
    import ialu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ialu_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output ialu_out_t out_data
);

    state_t      state_reg, state_next;
    logic [3:0]  flags_reg, flags_next;
    ialu_in_t    cmd_reg, cmd_next;
    logic [63:0] data_reg, data_next;
    logic        divz_reg, divz_next;
    logic        ovq_reg, ovq_next;
    logic        ovalid_reg, ovalid_next;
    ialu_out_t   obuf_reg, obuf_next;
    iter_req_t   req;
    iter_rsp_t   rsp;

    logic [5:0]  w;
    logic signed [63:0] da, db;
    logic [63:0] res64, wmask, quot64, prod64;
    logic        neg_a, neg_b, rneg, ov, cin, n, z, v, c, special;
    logic [3:0]  func;

    function automatic logic signed [63:0] sext(input logic [31:0] x, input logic [1:0] s);
        logic signed [63:0] r;
        unique case (s)
            SIZE_BYTE: r = {{56{x[7]}}, x[7:0]};
            SIZE_WORD: r = {{48{x[15]}}, x[15:0]};
            default:   r = {{32{x[31]}}, x};
        endcase
        return r;
    endfunction

    ialu_iter u_iter (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    // effective size, carry ops run at word
    logic [1:0] esz;
    assign func = cmd_reg.func;
    assign esz  = (func == FUNC_ADWC || func == FUNC_SBWC) ? SIZE_WORD : cmd_reg.size;
    assign w    = (esz == SIZE_BYTE) ? 6'd8 : (esz == SIZE_WORD) ? 6'd16 : 6'd32;
    assign da   = sext(cmd_reg.operand_a, esz);
    assign db   = sext(cmd_reg.operand_b, esz);
    assign cin  = flags_reg[0];
    assign neg_a = da[63];
    assign neg_b = db[63];
    assign rneg  = neg_a ^ neg_b;
    assign wmask = (64'd1 << w) - 64'd1;
    assign special = (func > 4'd8) || (cmd_reg.size == SIZE_BAD &&
                     func != FUNC_ADWC && func != FUNC_SBWC);

    // signed fixups of the unit's magnitude results
    assign prod64 = rneg ? (64'd0 - rsp.prod) : rsp.prod;
    assign quot64 = rneg ? (64'd0 - {32'd0, rsp.quot}) : {32'd0, rsp.quot};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_FIX;
            ST_FIX:
                if (!special && func == FUNC_MUL)
                    state_next = ST_MUL;
                else if (!special && func == FUNC_DIV && da != 64'sd0)
                    state_next = ST_DIV;
                else
                    state_next = ST_DONE;
            ST_MUL, ST_DIV:
                if (rsp.done)
                    state_next = ST_DONE;
            ST_DONE:
                if (!ovalid_reg || out_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd_next  = cmd_reg;
        data_next = data_reg;
        divz_next = divz_reg;
        ovq_next  = ovq_reg;
        flags_next = flags_reg;
        ovalid_next = ovalid_reg && !out_ready;
        obuf_next = obuf_reg;
        req = '0;
        res64 = 64'd0;
        n = 1'b0; z = 1'b0; v = 1'b0; c = 1'b0; ov = 1'b0;
        in_ready = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    cmd_next = in_data;
            ST_FIX:
            begin
                divz_next = 1'b0;
                ovq_next  = 1'b0;
                unique case (func)
                    FUNC_ADD:  data_next = db + da;
                    FUNC_ADWC: data_next = db + da + {63'd0, cin};
                    FUNC_SUB:  data_next = db - da;
                    FUNC_SBWC: data_next = db - da - {63'd0, cin};
                    FUNC_BIS:  data_next = db | da;
                    FUNC_BIC:  data_next = db & ~da;
                    FUNC_XOR:  data_next = db ^ da;
                    FUNC_DIV:
                    begin
                        data_next = db;
                        divz_next = (da == 64'sd0);
                    end
                    default:   data_next = db;
                endcase
                req.start  = !special && (func == FUNC_MUL ||
                             (func == FUNC_DIV && da != 64'sd0));
                req.is_div = (func == FUNC_DIV);
                req.mag_a  = neg_a ? 32'(64'd0 - da) : da[31:0];
                req.mag_b  = neg_b ? 32'(64'd0 - db) : db[31:0];
            end
            ST_MUL:
                if (rsp.done)
                    data_next = prod64;
            ST_DIV:
                if (rsp.done)
                begin
                    data_next = quot64;
                    // only most negative / -1 overflows; magnitude 2^31
                    ovq_next  = !rneg && rsp.quot[31];
                end
            ST_DONE:
                if (!ovalid_reg || out_ready)
                begin
                    res64 = data_reg & wmask;
                    n = res64[w - 6'd1];
                    z = (res64 == 64'd0);
                    unique case (w)
                        6'd8:    ov = ($signed(data_reg) > 64'sd127) ||
                                      ($signed(data_reg) < -64'sd128);
                        6'd16:   ov = ($signed(data_reg) > 64'sd32767) ||
                                      ($signed(data_reg) < -64'sd32768);
                        default: ov = ($signed(data_reg) > 64'sd2147483647) ||
                                      ($signed(data_reg) < -64'sd2147483648);
                    endcase
                    if (func == FUNC_XOR)
                        v = 1'b0;
                    else if (divz_reg)
                        v = 1'b1;
                    else
                        v = ov || ovq_reg;
                    if (func == FUNC_BIS)
                        c = 1'b0;
                    else if (func == FUNC_XOR || w == 6'd32)
                        c = cin;
                    else
                        c = data_reg[w];
                    ovalid_next = 1'b1;
                    if (special)
                    begin
                        obuf_next = '{result: 32'd0, flag_n: flags_reg[3],
                                      flag_z: flags_reg[2], flag_v: flags_reg[1],
                                      flag_c: flags_reg[0], fault: (func <= 4'd8)};
                    end
                    else
                    begin
                        flags_next = {n, z, v, c};
                        obuf_next = '{result: res64[31:0], flag_n: n, flag_z: z,
                                      flag_v: v, flag_c: c, fault: 1'b0};
                    end
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            flags_reg  <= 4'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            flags_reg  <= flags_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        data_reg <= data_next;
        divz_reg <= divz_next;
        ovq_reg  <= ovq_next;
        obuf_reg <= obuf_next;
    end

    assign out_valid = ovalid_reg;
    assign out_data  = obuf_reg;

endmodule

[verif/integer_alu_with_flags_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_alu_with_flags_unit_tb
// Drives alu words through the valid/ready input, predicts result and N Z V C
// flags with a local condition-code model, and checks every output word in
// order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module integer_alu_with_flags_unit_tb;
    import ialu_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    ialu_in_t  in_data;
    logic      out_valid;
    logic      out_ready;
    ialu_out_t out_data;

    ialu_in_t  pending_words[$];
    ialu_out_t expected_results[$];
    logic [3:0] cc_flags;
    int        error_count;
    int        words_sent;
    int        words_checked;
    int        cycle_count;
    bit        stim_done;
    bit        hold_output;
    int        burst_left;
    int        gap_left;

    integer_alu_with_flags_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sign extend the low w bits
    function automatic longint sext_at(logic [31:0] v, int w);
        longint x;
        x = longint'(v) & ((64'sd1 <<< w) - 1);
        if ((x >>> (w - 1)) & 1)
            x = x - (64'sd1 <<< w);
        return x;
    endfunction

    // predict one alu word and update the held flags
    function automatic ialu_out_t alu_predict(ialu_in_t w_in);
        ialu_out_t r;
        int        w;
        longint    da, db, acc, hi, lo;
        logic [63:0] raw;
        logic [31:0] res;
        bit        divz, n, z, v, c, cin;
        r = '0;
        cin = cc_flags[0];
        divz = 1'b0;
        if (w_in.func > FUNC_SBWC || (w_in.size == SIZE_BAD &&
            w_in.func != FUNC_ADWC && w_in.func != FUNC_SBWC))
        begin
            r.fault = (w_in.func <= FUNC_SBWC);
            {r.flag_n, r.flag_z, r.flag_v, r.flag_c} = cc_flags;
            return r;
        end
        if (w_in.func == FUNC_ADWC || w_in.func == FUNC_SBWC)
            w = 16;
        else
            w = (w_in.size == SIZE_BYTE) ? 8 : (w_in.size == SIZE_WORD) ? 16 : 32;
        da = sext_at(w_in.operand_a, w);
        db = sext_at(w_in.operand_b, w);
        case (func_t'(w_in.func))
            FUNC_ADD, FUNC_ADWC: acc = db + da;
            FUNC_SUB, FUNC_SBWC: acc = db - da;
            FUNC_MUL: acc = db * da;
            FUNC_DIV:
            begin
                if (da == 0)
                begin
                    divz = 1'b1;
                    acc = db;
                end
                else
                    acc = db / da;
            end
            FUNC_BIS: acc = db | da;
            FUNC_BIC: acc = db & ~da;
            default:  acc = db ^ da;
        endcase
        if (w_in.func == FUNC_ADWC)
            acc = acc + cin;
        if (w_in.func == FUNC_SBWC)
            acc = acc - cin;
        raw = acc;
        res = raw[31:0] & 32'((64'd1 << w) - 1);
        n = res[w - 1];
        z = (res == 0);
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (w_in.func == FUNC_XOR)
            v = 1'b0;
        else if (divz)
            v = 1'b1;
        else
            v = (acc > hi || acc < lo);
        if (w_in.func == FUNC_BIS)
            c = 1'b0;
        else if (w_in.func == FUNC_XOR || w == 32)
            c = cin;
        else
            c = raw[w];
        cc_flags = {n, z, v, c};
        r.result = res;
        {r.flag_n, r.flag_z, r.flag_v, r.flag_c} = cc_flags;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch word %0d %s: got %h want %h", words_checked, what, got, want);
        error_count++;
    endtask

    function automatic logic [31:0] edge_operand();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'h0000_0080 | ($urandom & 32'hFFFF_FF00);
            5: return 32'h0000_8000 | ($urandom & 32'hFFFF_0000);
            6: return $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    function automatic ialu_in_t make_word(int f, int s, logic [31:0] a, logic [31:0] b);
        ialu_in_t x;
        x.func = 4'(f);
        x.size = 2'(s);
        x.operand_a = a;
        x.operand_b = b;
        return x;
    endfunction

    // stimulus
    initial
    begin
        int f;
        int s;
        stim_done = 1'b0;
        // directed: every operation at byte and word, all but the carry ops at longword, with extremes
        for (f = 0; f <= 8; f++)
            for (s = 0; s <= 2; s++)
                if (!(s == 2 && f > 6))
                    pending_words.push_back(make_word(f, s,
                        (s == 0) ? 32'hFF : (s == 1) ? 32'hFFFF : 32'hFFFF_FFFF,
                        (s == 0) ? 32'h80 : (s == 1) ? 32'h8000 : 32'h8000_0000));
        pending_words.push_back(make_word(FUNC_DIV, SIZE_LONG, 32'h0, 32'h1234_5678));
        pending_words.push_back(make_word(FUNC_DIV, SIZE_BYTE, 32'h0, 32'h0000_0085));
        pending_words.push_back(make_word(FUNC_ADD, SIZE_WORD, 32'h8000, 32'h8000));
        pending_words.push_back(make_word(FUNC_ADWC, SIZE_BAD, 32'h1, 32'hFFFF));
        pending_words.push_back(make_word(FUNC_SBWC, SIZE_BAD, 32'h0, 32'h0));
        pending_words.push_back(make_word(FUNC_ADD, SIZE_BAD, 32'h1, 32'h1));
        pending_words.push_back(make_word(4'd15, SIZE_LONG, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_words.push_back(make_word(4'd9, SIZE_BYTE, 32'h0, 32'h0));
        // random part
        repeat (900)
        begin
            f = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
            s = ($urandom_range(0, 11) == 0) ? 3 : $urandom_range(0, 2);
            pending_words.push_back(make_word(f, s, edge_operand(), edge_operand()));
        end
        stim_done = 1'b1;
    end

    // reset and run end
    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done && pending_words.size() == 0 && !in_valid &&
              expected_results.size() == 0);
        repeat (50) @(posedge clk);
        $display("covered %0d words sent, %0d results checked, all funcs and sizes",
                 words_sent, words_checked);
        if (error_count == 0 && expected_results.size() == 0)
            $display("integer_alu_with_flags_unit verification clean");
        else
            $display("integer_alu_with_flags_unit verification failed");
        $finish;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("integer_alu_with_flags_unit verification failed");
            $finish;
        end
    end

    // driver: bursts and gaps, one drain pause midway
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_data    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (in_valid && !in_ready)
        begin
            // hold word until accepted
        end
        else
        begin
            if (in_valid)
            begin
                expected_results.push_back(alu_predict(in_data));
                words_sent++;
            end
            if (words_sent == 400 && in_valid)
            begin
                in_valid <= 1'b0;
                gap_left <= 0;
            end
            else if (words_sent >= 400 && words_sent < 401 && expected_results.size() != 0)
                in_valid <= 1'b0;
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_words.size() != 0)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_words.pop_front();
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 20);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall pattern with one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            hold_output <= 1'b0;
        end
        else
        begin
            if (words_sent == 200 && !hold_output)
            begin
                hold_output <= 1'b1;
                out_ready   <= 1'b0;
                repeat (300) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (cycle_count[9:8] == 2'b11)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // monitor: compare with the oldest expected result
    always @(posedge clk)
    begin
        ialu_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("unexpected result word %h", out_data);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_data.result !== want.result)
                    report_mismatch("result", out_data.result, want.result);
                if (out_data.flag_n !== want.flag_n)
                    report_mismatch("flag_n", 32'(out_data.flag_n), 32'(want.flag_n));
                if (out_data.flag_z !== want.flag_z)
                    report_mismatch("flag_z", 32'(out_data.flag_z), 32'(want.flag_z));
                if (out_data.flag_v !== want.flag_v)
                    report_mismatch("flag_v", 32'(out_data.flag_v), 32'(want.flag_v));
                if (out_data.flag_c !== want.flag_c)
                    report_mismatch("flag_c", 32'(out_data.flag_c), 32'(want.flag_c));
                if (out_data.fault !== want.fault)
                    report_mismatch("fault", 32'(out_data.fault), 32'(want.fault));
            end
            words_checked++;
        end
    end

    initial
    begin
        error_count   = 0;
        words_sent    = 0;
        words_checked = 0;
        cycle_count   = 0;
        cc_flags      = 4'h0;
    end

endmodule

[sim.f]
sv/ialu_pkg.sv
sv/ialu_iter.sv
sv/integer_alu_with_flags_unit.sv
verif/integer_alu_with_flags_unit_tb.sv
